### src/gtg_pkg.sv
// Package: shared types, constants and tables of the go-to-goal controller.
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int QueueDepth = 16;
  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  localparam logic [2:0] CMD_POSE   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_RESUME = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  localparam logic [2:0] REG_LINEAR_GAIN  = 3'd0;
  localparam logic [2:0] REG_HEADING_GAIN = 3'd1;
  localparam logic [2:0] REG_TOLERANCE    = 3'd2;
  localparam logic [2:0] REG_HOME_X       = 3'd3;
  localparam logic [2:0] REG_HOME_Y       = 3'd4;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  localparam logic signed [22:0] QuarterTurn = 23'sd102944;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;      // capture item, compute dx, dy
    logic square;    // form the squared distance
    logic root_step; // one square root step
    logic cordic_init;
    logic cordic_step;
    logic speed_mul;
    logic turn_mul;
    logic finish;    // form result and update goal
  } gtg_cmd_t;

  typedef struct packed {
    logic root_done;
    logic cordic_done;
  } gtg_status_t;

  // Arctangent table, units 2^-16 rad.
  function automatic logic signed [22:0] atan_lut(input logic [3:0] i);
    logic signed [22:0] v;
    case (i)
      4'd0: v = 23'sd51472;
      4'd1: v = 23'sd30385;
      4'd2: v = 23'sd16055;
      4'd3: v = 23'sd8150;
      4'd4: v = 23'sd4091;
      4'd5: v = 23'sd2047;
      4'd6: v = 23'sd1024;
      4'd7: v = 23'sd512;
      4'd8: v = 23'sd256;
      4'd9: v = 23'sd128;
      4'd10: v = 23'sd64;
      4'd11: v = 23'sd32;
      4'd12: v = 23'sd16;
      4'd13: v = 23'sd8;
      4'd14: v = 23'sd4;
      default: v = 23'sd2;
    endcase
    return v;
  endfunction

endpackage

### src/gtg_if.sv
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface gtg_in_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, command, pos_x, pos_y, heading, input ready);
  modport sink (input valid, command, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_out_if;
  logic valid;
  logic ready;
  logic [16:0] linear_speed;
  logic signed [17:0] turn_rate;
  logic arrived;
  modport source (output valid, linear_speed, turn_rate, arrived, input ready);
  modport sink (input valid, linear_speed, turn_rate, arrived, output ready);
endinterface

### src/gtg_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module gtg_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/gtg_datapath.sv
// Datapath: distance root, CORDIC bearing, gains and goal registers.
`timescale 1ns / 1ps
module gtg_datapath (
  input  logic                  clk,
  input  gtg_pkg::gtg_cmd_t     cmd,
  output gtg_pkg::gtg_status_t  status,
  input  logic signed [15:0]    in_x,
  input  logic signed [15:0]    in_y,
  input  logic signed [15:0]    in_heading,
  input  logic [15:0]           linear_gain,
  input  logic [15:0]           heading_gain,
  input  logic [14:0]           arrive_tolerance,
  input  logic [14:0]           home_x,
  input  logic [14:0]           home_y,
  input  logic [1:0]            drive_mode,
  input  logic                  store_nonempty,
  input  logic [31:0]           store_rdata,
  input  logic signed [15:0]    goal_x,
  input  logic signed [15:0]    goal_y,
  output logic                  near_goal,
  output logic [16:0]           res_speed,
  output logic signed [17:0]    res_turn,
  output logic                  res_arrived,
  output logic                  goal_we,
  output logic signed [15:0]    goal_x_next,
  output logic signed [15:0]    goal_y_next
);
  import gtg_pkg::*;

  logic signed [16:0] dx, dy;
  logic signed [15:0] hd;
  logic [33:0] rad;     // squared distance
  logic [16:0] root;
  logic [16:0] rbit;    // current root bit (one-hot), steps of 1
  logic signed [34:0] cx, cy;
  logic signed [22:0] cz;
  logic [3:0] ci;
  logic [32:0] speed_prod;
  logic signed [36:0] turn_prod;

  // Square root, restoring, one result bit a cycle.
  logic [33:0] sq_x, sq_y;
  assign sq_x = 34'(dx * dx);
  assign sq_y = 34'(dy * dy);

  logic [35:0] root_sq_try;
  logic [16:0] root_try;
  assign root_try = root | rbit;
  assign root_sq_try = 36'(root_try) * 36'(root_try);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx <= 17'(goal_x) - 17'(in_x);
      dy <= 17'(goal_y) - 17'(in_y);
      hd <= in_heading;
    end
    if (cmd.square) begin
      rad  <= sq_x + sq_y;
      root <= '0;
      rbit <= 17'h10000;
    end
    if (cmd.root_step) begin
      if (root_sq_try <= {2'b00, rad}) begin
        root <= root_try;
      end
      rbit <= rbit >> 1;
    end
  end
  assign status.root_done = rbit == '0;
  assign near_goal = {2'b00, root} <= {4'b0000, arrive_tolerance};

  // CORDIC vectoring, one iteration a cycle.
  logic signed [34:0] sx, sy;
  assign sx = cx >>> ci;
  assign sy = cy >>> ci;
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      ci <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          cx <= 35'(dy) <<< 16;
          cy <= (-35'(dx)) <<< 16;
          cz <= QuarterTurn;
        end else begin
          cx <= (-35'(dy)) <<< 16;
          cy <= 35'(dx) <<< 16;
          cz <= -QuarterTurn;
        end
      end else begin
        cx <= 35'(dx) <<< 16;
        cy <= 35'(dy) <<< 16;
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (cy >= 0) begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + atan_lut(ci);
      end else begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - atan_lut(ci);
      end
      ci <= ci + 4'd1;
    end
  end
  assign status.cordic_done = cmd.cordic_step && ci == 4'd15;

  // Gain products, registered.
  logic signed [20:0] bearing;
  logic signed [21:0] err;
  logic signed [22:0] cz4;
  assign cz4 = cz + 23'sd4;
  assign bearing = 21'(cz4 >>> 3);
  assign err = 22'(bearing) - 22'(hd);
  always_ff @(posedge clk) begin
    if (cmd.speed_mul) begin
      speed_prod <= 33'(linear_gain) * 33'(root);
    end
    if (cmd.turn_mul) begin
      turn_prod <= $signed({21'b0, heading_gain}) * 37'(err);
    end
  end

  // Result forming and goal update.
  logic [33:0] speed_r;
  logic signed [36:0] turn_r;
  logic running;
  assign running = drive_mode == MODE_RUN;
  assign speed_r = 34'(speed_prod) + 34'd2048;
  assign turn_r = (turn_prod + 37'sd8192) >>> 14;
  always_comb begin
    res_speed = '0;
    res_turn = '0;
    res_arrived = 1'b0;
    goal_we = 1'b0;
    goal_x_next = goal_x;
    goal_y_next = goal_y;
    if (near_goal) begin
      res_arrived = 1'b1;
      if (store_nonempty) begin
        goal_we = 1'b1;
        goal_x_next = store_rdata[15:0];
        goal_y_next = store_rdata[31:16];
      end
    end else if (!running) begin
      if (drive_mode == MODE_RESET) begin
        goal_we = 1'b1;
        goal_x_next = {1'b0, home_x};
        goal_y_next = {1'b0, home_y};
      end
    end else begin
      res_speed = (speed_r[33:12] > 22'd131071) ? 17'h1FFFF : speed_r[28:12];
      if (turn_r > 37'sd131071) res_turn = 18'sd131071;
      else if (turn_r < -37'sd131072) res_turn = -18'sd131072;
      else res_turn = turn_r[17:0];
    end
  end
endmodule

### src/gtg_ctrl.sv
// Controller: sequences load, root, CORDIC, products and result.
`timescale 1ns / 1ps
module gtg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_command,
  input  logic                  near_goal,
  input  logic                  running,
  input  gtg_pkg::gtg_status_t  status,
  output gtg_pkg::gtg_cmd_t     cmd,
  output logic                  out_load,
  input  logic                  out_free
);
  import gtg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_ROOT   = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_CORDIC = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_DONE   = 8'b0100_0000,
    S_INIT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_command == CMD_POSE) begin
          cmd.load = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) begin
          cmd.root_step = 1'b0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.speed_mul = 1'b1;
        if (near_goal || !running) begin
          state_next = S_DONE;
        end else begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.cordic_init = 1'b1;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (status.cordic_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.turn_mul = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

### src/go_to_goal_waypoint_controller_top.sv
// Top level: proportional go-to-goal controller with waypoint queue.
//
// Usage: one input channel carries command words (pose sample, add waypoint,
// stop, resume, reset); one output channel carries a result word for each
// pose sample and nothing for other commands. Configuration registers
// (gains, arrival tolerance, home point) are written through a write port;
// the user must write them only while the block is idle, which the block
// itself does not enforce. A pose sample within tolerance or taken while
// stopped skips the CORDIC; otherwise 17 square root steps and 16 CORDIC
// iterations of the shared units run in turn.
// One pose sample is processed at a time.
// Reset clears the goal to the origin, the queue to empty, the drive mode
// to running and loads the default registers.
// A result waits in an output register; if the receiver stalls, the next
// pose sample is held at its final step until the register frees.
`timescale 1ns / 1ps
module go_to_goal_waypoint_controller_top (
  input  logic        clk,
  input  logic        rst,
  gtg_in_if.sink      in_ch,
  gtg_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gtg_pkg::*;

  logic [15:0] linear_gain, heading_gain;
  logic [14:0] arrive_tolerance, home_x, home_y;
  logic [1:0] drive_mode;
  logic signed [15:0] goal_x, goal_y;
  logic [PtrW-1:0] rd_ptr, wr_ptr;
  logic [CntW-1:0] count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain <= 16'd6144;
      heading_gain <= 16'd14336;
      arrive_tolerance <= 15'd20;
      home_x <= 15'd11346;
      home_y <= 15'd11346;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_GAIN:  linear_gain <= cfg_data;
        REG_HEADING_GAIN: heading_gain <= cfg_data;
        REG_TOLERANCE:    arrive_tolerance <= cfg_data[14:0];
        REG_HOME_X:       home_x <= cfg_data[14:0];
        REG_HOME_Y:       home_y <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  gtg_cmd_t cmd;
  gtg_status_t status;
  logic near_goal, out_load, goal_we, res_arrived;
  logic [16:0] res_speed;
  logic signed [17:0] res_turn;
  logic signed [15:0] goal_x_next, goal_y_next;
  logic [31:0] store_rdata;
  logic in_acc, store_we;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign store_we = in_acc && in_ch.command == CMD_ADD && count < CntW'(QueueDepth);

  gtg_ram #(.Width(32), .Depth(QueueDepth)) u_store (
    .clk(clk), .we(store_we), .waddr(wr_ptr),
    .wdata({in_ch.pos_y, in_ch.pos_x}), .raddr(rd_ptr), .rdata(store_rdata)
  );

  gtg_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_command(in_ch.command), .near_goal(near_goal),
    .running(drive_mode == MODE_RUN), .status(status), .cmd(cmd),
    .out_load(out_load), .out_free(!out_ch.valid || out_ch.ready)
  );

  gtg_datapath u_dp (
    .clk(clk), .cmd(cmd), .status(status),
    .in_x(in_ch.pos_x), .in_y(in_ch.pos_y), .in_heading(in_ch.heading),
    .linear_gain(linear_gain), .heading_gain(heading_gain),
    .arrive_tolerance(arrive_tolerance), .home_x(home_x), .home_y(home_y),
    .drive_mode(drive_mode), .store_nonempty(count != '0),
    .store_rdata(store_rdata), .goal_x(goal_x), .goal_y(goal_y),
    .near_goal(near_goal), .res_speed(res_speed), .res_turn(res_turn),
    .res_arrived(res_arrived), .goal_we(goal_we),
    .goal_x_next(goal_x_next), .goal_y_next(goal_y_next)
  );

  logic pop;
  assign pop = out_load && near_goal && count != '0;

  // Goal, drive mode and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0;
      goal_y <= '0;
      drive_mode <= MODE_RUN;
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (out_load && goal_we) begin
        goal_x <= goal_x_next;
        goal_y <= goal_y_next;
      end
      if (out_load && !near_goal && drive_mode == MODE_RESET) drive_mode <= MODE_RUN;
      if (in_acc) begin
        case (in_ch.command)
          CMD_STOP:   drive_mode <= MODE_STOP;
          CMD_RESUME: drive_mode <= MODE_RUN;
          CMD_RESET:  drive_mode <= MODE_RESET;
          default: ;
        endcase
      end
      if (store_we) wr_ptr <= (32'(wr_ptr) == QueueDepth - 1) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (32'(rd_ptr) == QueueDepth - 1) ? '0 : rd_ptr + 1'b1;
      count <= count + CntW'(store_we) - CntW'(pop);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.linear_speed <= res_speed;
      out_ch.turn_rate <= res_turn;
      out_ch.arrived <= res_arrived;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth)) else $error("queue count overflow");
  a_arrive_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.arrived |-> out_ch.linear_speed == '0 && out_ch.turn_rate == '0)
    else $error("arrival with nonzero command");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_ch.valid || out_ch.ready) else $error("result overwritten");
`endif
endmodule
